/* hdl/sfb_pkg.sv */
// Shared types, constants and the CRC-32 byte update of the frame builder.
`timescale 1ns / 1ps

package sfb_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;
    localparam logic [7:0]  HDR_BYTE0  = 8'hAA;
    localparam logic [7:0]  HDR_BYTE1  = 8'h55;

    // One accepted payload byte with everything the emitter needs.
    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] seq;
        logic [31:0] crc_out;   // final CRC, already inverted
        logic        hdr;       // first byte of a frame: header goes first
        logic        last;      // last byte of a frame: CRC follows
    } item_t;

    // Reflected CRC-32, one byte, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/sfb_ingest.sv */
// Input register, frame tracking and running CRC of the frame builder.
`timescale 1ns / 1ps

module sfb_ingest (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,
    input  logic          s_tlast,
    input  logic          item_done,
    output logic          item_valid,
    output sfb_pkg::item_t item
);

    logic           item_valid_reg, item_valid_next;
    sfb_pkg::item_t item_reg, item_next;
    logic           in_frame_reg, in_frame_next;
    logic [31:0]    crc_reg, crc_next;
    logic [31:0]    crc_upd;
    logic           accept;

    assign s_tready = !item_valid_reg || item_done;
    assign accept   = s_tvalid && s_tready;

    // The running CRC is all ones whenever no frame is open.
    assign crc_upd = sfb_pkg::crc_byte(crc_reg, s_tdata[7:0]);

    always_comb begin
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        in_frame_next   = in_frame_reg;
        crc_next        = crc_reg;
        if (item_done) begin
            item_valid_next = 1'b0;
        end
        if (accept) begin
            item_valid_next   = 1'b1;
            item_next.data    = s_tdata[7:0];
            item_next.seq     = s_tdata[23:8];
            item_next.crc_out = crc_upd ^ sfb_pkg::CRC_XOROUT;
            item_next.hdr     = !in_frame_reg;
            item_next.last    = s_tlast;
            if (s_tlast) begin
                in_frame_next = 1'b0;
                crc_next      = sfb_pkg::CRC_INIT;
            end else begin
                in_frame_next = 1'b1;
                crc_next      = crc_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            in_frame_reg   <= 1'b0;
            crc_reg        <= sfb_pkg::CRC_INIT;
        end else begin
            item_valid_reg <= item_valid_next;
            in_frame_reg   <= in_frame_next;
            crc_reg        <= crc_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    // Outside a frame the running CRC must sit at its initial value.
    a_idle_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> crc_reg == sfb_pkg::CRC_INIT)
        else $error("CRC not reinitialized outside a frame");

    // A last byte closes the frame.
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> !in_frame_reg)
        else $error("frame still open after last byte");

endmodule

/* hdl/sfb_emit.sv */
// Byte sequencer and output register of the frame builder.
`timescale 1ns / 1ps

module sfb_emit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    input  sfb_pkg::item_t item,
    output logic           item_done,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);

    localparam logic [3:0] PH_HDR0 = 4'd0;
    localparam logic [3:0] PH_HDR1 = 4'd1;
    localparam logic [3:0] PH_SEQL = 4'd2;
    localparam logic [3:0] PH_SEQH = 4'd3;
    localparam logic [3:0] PH_DATA = 4'd4;
    localparam logic [3:0] PH_CRC0 = 4'd5;
    localparam logic [3:0] PH_CRC1 = 4'd6;
    localparam logic [3:0] PH_CRC2 = 4'd7;
    localparam logic [3:0] PH_CRC3 = 4'd8;

    logic       started_reg, started_next;
    logic [3:0] phase_reg, phase_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic [3:0] cur_phase, end_phase;
    logic       load;
    logic [7:0] sel_byte;

    assign cur_phase = started_reg ? phase_reg : (item.hdr ? PH_HDR0 : PH_DATA);
    assign end_phase = item.last ? PH_CRC3 : PH_DATA;
    assign load      = item_valid && (!m_tvalid_reg || m_tready);
    assign item_done = load && (cur_phase == end_phase);

    always_comb begin
        case (cur_phase)
            PH_HDR0: sel_byte = sfb_pkg::HDR_BYTE0;
            PH_HDR1: sel_byte = sfb_pkg::HDR_BYTE1;
            PH_SEQL: sel_byte = item.seq[7:0];
            PH_SEQH: sel_byte = item.seq[15:8];
            PH_DATA: sel_byte = item.data;
            PH_CRC0: sel_byte = item.crc_out[7:0];
            PH_CRC1: sel_byte = item.crc_out[15:8];
            PH_CRC2: sel_byte = item.crc_out[23:16];
            PH_CRC3: sel_byte = item.crc_out[31:24];
            default: sel_byte = item.data;
        endcase
    end

    always_comb begin
        started_next  = started_reg;
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = sel_byte;
            m_tlast_next  = (cur_phase == PH_CRC3);
            if (item_done) begin
                started_next = 1'b0;
            end else begin
                started_next = 1'b1;
                phase_next   = cur_phase + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            phase_reg    <= PH_HDR0;
            m_tvalid_reg <= 1'b0;
        end else begin
            started_reg  <= started_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Mid-item the sequencer never runs past the last CRC byte.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> phase_reg <= PH_CRC3)
        else $error("phase out of range");

    // Frame end is flagged exactly on the fourth CRC byte.
    a_end_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tlast_reg == ($past(cur_phase) == PH_CRC3))
        else $error("frame end flag misplaced");

endmodule

/* hdl/seq_frame_builder_crc32_core.sv */
// Top level of the sequence-numbered frame builder with CRC-32 trailer.
`timescale 1ns / 1ps

// Usage:
// The slave channel takes one payload byte per transfer: s_tdata carries the
// byte and the 16-bit sequence number, s_tlast marks the final payload byte.
// The sequence number is only looked at on the first byte of a frame.
// The master channel gives one framed byte per transfer on m_tdata. A frame
// opens with AA 55 and the sequence number low byte first, then the payload
// bytes, then the reflected CRC-32 of the payload, low byte first; m_tlast
// is high on the last CRC byte.
// Each byte passes through the input register and then the output register.
// Throughput is one output byte per cycle while m_tready is high; a middle
// payload byte gives one output byte, a first or last byte five, and a
// single-byte frame nine, as the byte sequencer walks header, payload, CRC.
// The next payload byte is taken in the same cycle the sequencer finishes the
// current one, so a frame streams without gaps.
// When the receiver stalls, the output register holds its byte and the input
// channel backs up after one buffered payload byte.
// Reset clears both registers' valid flags, closes any open frame and returns
// the running CRC to all ones.

module seq_frame_builder_crc32_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] payload_byte, [23:8] frame_seq
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // frame_end
);

    logic           item_valid;
    logic           item_done;
    sfb_pkg::item_t item;

    // Input register: latches the byte, tracks frame state and runs the CRC.
    sfb_ingest u_ingest (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_done  (item_done),
        .item_valid (item_valid),
        .item       (item)
    );

    // Sequencer and output register: header, byte and CRC, one per transfer.
    sfb_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_done  (item_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
